// ===== src/lzss_ring_decompressor_top_assert.svh =====
// assertion macros for the lzss ring decompressor
`ifndef LZSS_RING_DECOMPRESSOR_TOP_ASSERT_SVH
`define LZSS_RING_DECOMPRESSOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LZSSRD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define LZSSRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LZSSRD_ASSERT_IMPL(lbl, ante, cons, msg)
`define LZSSRD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/lzssrd_pkg.sv =====
// shared types and constants of the lzss ring decompressor
package lzssrd_pkg;

  localparam int DEF_RING_BITS        = 9;
  localparam int DEF_START_GAP        = 66;
  localparam int DEF_BYTES_PER_RESULT = 4;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 8;
  localparam int LEN_OFFSET  = 3;
  localparam int FLAG_COUNT  = 8;
  localparam int LEFT_W      = 4;
  localparam int CNT_W       = 4;
  localparam int OUT_SLOTS   = 4;
  localparam int WORD_W      = 32;
  localparam int OUT_CNT_W   = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_PAIR
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic lit_go;
    logic hold_low;
    logic copy_start;
    logic copy_run;
    logic ring_clear;
  } cmd_t;

  typedef struct packed {
    logic emit_busy;
    logic copy_done;
  } stat_t;

endpackage

// ===== src/lzssrd_ram.sv =====
// generic single write, single read ram with registered read data
module lzssrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/lzssrd_ctrl.sv =====
// token decoder and sequencing state machine
module lzssrd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic [lzssrd_pkg::BYTE_W-1:0] in_byte,
  input  logic                        in_last,
  output logic                        in_tready,
  output lzssrd_pkg::cmd_t            cmd,
  input  lzssrd_pkg::stat_t           stat
);

  lzssrd_pkg::ctrl_state_t state_r, state_nxt;
  lzssrd_pkg::phase_t      phase_r, phase_nxt;
  logic [lzssrd_pkg::BYTE_W-1:0] flag_shift_r, flag_shift_nxt;
  logic [lzssrd_pkg::LEFT_W-1:0] flags_left_r, flags_left_nxt;
  logic                          eos_r, eos_nxt;
  logic [lzssrd_pkg::LEFT_W-1:0] left_dec;
  logic                          accept;

  assign in_tready = (state_r == lzssrd_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign left_dec  = flags_left_r - lzssrd_pkg::LEFT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lzssrd_pkg::ST_IDLE;
      phase_r      <= lzssrd_pkg::PH_FLAG;
      flag_shift_r <= '0;
      flags_left_r <= '0;
      eos_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      flag_shift_r <= flag_shift_nxt;
      flags_left_r <= flags_left_nxt;
      eos_r        <= eos_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    flag_shift_nxt = flag_shift_r;
    flags_left_nxt = flags_left_r;
    eos_nxt        = eos_r;
    cmd            = '0;
    unique case (state_r)
      lzssrd_pkg::ST_IDLE: begin
        if (accept) begin
          eos_nxt   = in_last;
          state_nxt = lzssrd_pkg::ST_DRAIN;
          unique case (phase_r)
            lzssrd_pkg::PH_TOKEN: begin
              if (flag_shift_r[0]) begin
                cmd.lit_go     = 1'b1;
                flag_shift_nxt = flag_shift_r >> 1;
                flags_left_nxt = left_dec;
                phase_nxt      = (left_dec == '0) ? lzssrd_pkg::PH_FLAG
                                                  : lzssrd_pkg::PH_TOKEN;
              end else begin
                cmd.hold_low = 1'b1;
                phase_nxt    = lzssrd_pkg::PH_PAIR;
              end
            end
            lzssrd_pkg::PH_PAIR: begin
              cmd.copy_start = 1'b1;
              state_nxt      = lzssrd_pkg::ST_COPY;
              flag_shift_nxt = flag_shift_r >> 1;
              flags_left_nxt = left_dec;
              phase_nxt      = (left_dec == '0) ? lzssrd_pkg::PH_FLAG
                                                : lzssrd_pkg::PH_TOKEN;
            end
            default: begin
              flag_shift_nxt = in_byte;
              flags_left_nxt = lzssrd_pkg::LEFT_W'(lzssrd_pkg::FLAG_COUNT);
              phase_nxt      = lzssrd_pkg::PH_TOKEN;
            end
          endcase
          // end of stream: decoder state restarts now, the ring after the last write
          if (in_last) begin
            phase_nxt      = lzssrd_pkg::PH_FLAG;
            flag_shift_nxt = '0;
            flags_left_nxt = '0;
          end
        end
      end
      lzssrd_pkg::ST_COPY: begin
        cmd.copy_run = 1'b1;
        if (stat.copy_done) begin
          state_nxt = lzssrd_pkg::ST_DRAIN;
        end
      end
      lzssrd_pkg::ST_DRAIN: begin
        if (!stat.emit_busy) begin
          cmd.ring_clear = eos_r;
          state_nxt      = lzssrd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lzssrd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/lzssrd_dp.sv =====
// history ring, copy address path, byte packer and output register
`include "lzss_ring_decompressor_top_assert.svh"
module lzssrd_dp #(
  parameter int RING_BITS        = lzssrd_pkg::DEF_RING_BITS,
  parameter int START_GAP        = lzssrd_pkg::DEF_START_GAP,
  parameter int BYTES_PER_RESULT = lzssrd_pkg::DEF_BYTES_PER_RESULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lzssrd_pkg::cmd_t                 cmd,
  output lzssrd_pkg::stat_t                stat,
  input  logic [lzssrd_pkg::BYTE_W-1:0]    in_byte,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [lzssrd_pkg::WORD_W-1:0]    out_word,
  output logic [lzssrd_pkg::OUT_CNT_W-1:0] out_cnt,
  output logic                             out_last
);

  localparam int RING_SIZE = 2 ** RING_BITS;
  localparam logic [RING_BITS-1:0] START_POS =
    RING_BITS'((RING_SIZE - START_GAP) % RING_SIZE);
  localparam int HI_LSB = 16 - RING_BITS;
  localparam int LEN_MSB = 15 - RING_BITS;

  logic [RING_BITS-1:0] wp_r, wp_nxt;
  logic [RING_BITS:0]   fill_r, fill_nxt;
  logic [RING_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lzssrd_pkg::LEN_W-1:0] rem_r, rem_nxt;
  logic [lzssrd_pkg::BYTE_W-1:0] held_r;

  // emit stage: one byte per beat into the ring and the packer, held while a full result is stalled
  logic e_v_r, e_v_nxt;
  logic e_lit_r, e_last_r, e_fwd_r, e_filled_r;
  logic [lzssrd_pkg::BYTE_W-1:0] e_lit_data_r, e_fwd_data_r;

  logic [lzssrd_pkg::WORD_W-1:0] acc_word_r, acc_word_nxt;
  logic [lzssrd_pkg::CNT_W-1:0]  acc_cnt_r, acc_cnt_nxt;

  logic                              out_v_r, out_v_nxt;
  logic [lzssrd_pkg::WORD_W-1:0]     out_word_r;
  logic [lzssrd_pkg::OUT_CNT_W-1:0]  out_cnt_r;
  logic                              out_last_r;

  logic [lzssrd_pkg::BYTE_W-1:0] ram_rd;
  logic [lzssrd_pkg::BYTE_W-1:0] e_byte;
  logic [RING_BITS-1:0]          rd_off;
  logic                          rd_filled;
  logic                          rd_issue;
  logic                          e_fire;
  logic                          emit_stall;
  logic                          flush;
  logic [lzssrd_pkg::CNT_W-1:0]  cnt_inc;
  logic [lzssrd_pkg::WORD_W-1:0] word_base;
  logic [lzssrd_pkg::WORD_W-1:0] word_new;
  logic [4:0]                    shamt;

  lzssrd_ram #(
    .WIDTH (lzssrd_pkg::BYTE_W),
    .DEPTH (RING_SIZE)
  ) u_ring (
    .clk     (clk),
    .wr_en   (e_fire),
    .wr_addr (wp_r),
    .wr_data (e_byte),
    .rd_en   (rd_issue),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rd)
  );

  // entries are written in order from the start position, so the fill count tells
  // which ones are still unwritten, and those read as zero
  assign rd_off    = rd_ptr_r - START_POS;
  assign rd_filled = ({1'b0, rd_off} < fill_r);

  always_comb begin
    if (e_lit_r) begin
      e_byte = e_lit_data_r;
    end else if (e_fwd_r) begin
      e_byte = e_fwd_data_r;
    end else if (e_filled_r) begin
      e_byte = ram_rd;
    end else begin
      e_byte = '0;
    end
  end

  assign cnt_inc   = acc_cnt_r + lzssrd_pkg::CNT_W'(1);
  assign flush     = (cnt_inc >= lzssrd_pkg::CNT_W'(BYTES_PER_RESULT)) || e_last_r;
  assign emit_stall = e_v_r && flush && out_v_r && !out_tready;
  assign e_fire    = e_v_r && !emit_stall;
  assign rd_issue  = cmd.copy_run && (rem_r != '0) && !emit_stall;

  assign word_base = (acc_cnt_r == '0) ? '0 : acc_word_r;
  assign shamt     = {acc_cnt_r[1:0], 3'b000};

  // bytes past the fourth slot do not fit the result word
  always_comb begin
    word_new = word_base;
    if (acc_cnt_r < lzssrd_pkg::CNT_W'(lzssrd_pkg::OUT_SLOTS)) begin
      word_new = word_base | (lzssrd_pkg::WORD_W'(e_byte) << shamt);
    end
  end

  always_comb begin
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    rd_ptr_nxt   = rd_ptr_r;
    rem_nxt      = rem_r;
    e_v_nxt      = e_v_r;
    acc_word_nxt = acc_word_r;
    acc_cnt_nxt  = acc_cnt_r;
    out_v_nxt    = out_v_r;
    if (out_v_r && out_tready) begin
      out_v_nxt = 1'b0;
    end
    if (e_fire) begin
      e_v_nxt = 1'b0;
      wp_nxt  = wp_r + RING_BITS'(1);
      if (fill_r != (RING_BITS+1)'(RING_SIZE)) begin
        fill_nxt = fill_r + (RING_BITS+1)'(1);
      end
      if (flush) begin
        out_v_nxt   = 1'b1;
        acc_cnt_nxt = '0;
      end else begin
        acc_word_nxt = word_new;
        acc_cnt_nxt  = cnt_inc;
      end
    end
    if (cmd.copy_start) begin
      rd_ptr_nxt = {in_byte[7:HI_LSB], held_r};
      rem_nxt    = lzssrd_pkg::LEN_W'(in_byte[LEN_MSB:0])
                 + lzssrd_pkg::LEN_W'(lzssrd_pkg::LEN_OFFSET);
    end else if (rd_issue) begin
      rd_ptr_nxt = rd_ptr_r + RING_BITS'(1);
      rem_nxt    = rem_r - lzssrd_pkg::LEN_W'(1);
    end
    if (rd_issue || cmd.lit_go) begin
      e_v_nxt = 1'b1;
    end
    if (cmd.ring_clear) begin
      wp_nxt   = START_POS;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= START_POS;
      fill_r    <= '0;
      rem_r     <= '0;
      e_v_r     <= 1'b0;
      acc_cnt_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      wp_r      <= wp_nxt;
      fill_r    <= fill_nxt;
      rem_r     <= rem_nxt;
      e_v_r     <= e_v_nxt;
      acc_cnt_r <= acc_cnt_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r   <= rd_ptr_nxt;
    acc_word_r <= acc_word_nxt;
    if (cmd.hold_low) begin
      held_r <= in_byte;
    end
    if (rd_issue) begin
      e_lit_r    <= 1'b0;
      e_last_r   <= (rem_r == lzssrd_pkg::LEN_W'(1));
      // byte written this same beat at the read address comes straight across
      e_fwd_r      <= e_fire && (rd_ptr_r == wp_r);
      e_fwd_data_r <= e_byte;
      e_filled_r   <= rd_filled;
    end else if (cmd.lit_go) begin
      e_lit_r      <= 1'b1;
      e_last_r     <= 1'b1;
      e_lit_data_r <= in_byte;
    end
    if (e_fire && flush) begin
      out_word_r <= word_new;
      out_cnt_r  <= cnt_inc[lzssrd_pkg::OUT_CNT_W-1:0];
      out_last_r <= e_last_r;
    end
  end

  assign stat.emit_busy = e_v_r;
  assign stat.copy_done = (rem_r == '0);

  assign out_tvalid = out_v_r;
  assign out_word   = out_word_r;
  assign out_cnt    = out_cnt_r;
  assign out_last   = out_last_r;

  `LZSSRD_ASSERT_NEXT(a_emit_hold, emit_stall, e_v_r && $stable(e_lit_r) && $stable(e_last_r), "emit stage lost a byte while stalled")
  `LZSSRD_ASSERT_NEXT(a_last_tag, rd_issue && (rem_r == 8'd1), e_v_r && e_last_r && !e_lit_r, "final copy byte not tagged last")
  `LZSSRD_ASSERT_NEXT(a_out_hold, out_v_r && !out_tready, out_v_r && $stable(out_word_r) && $stable(out_last_r), "result overwritten before taken")

endmodule

// ===== src/lzss_ring_decompressor_top.sv =====
// top level of the lzss ring decompressor
//
// channel   dir  fields (low bit up)                           last
// in_*      in   tdata: in_byte[7:0]                           tlast = end_of_stream
// out_*     out  tdata: out_bytes[31:0], byte_count[34:32]     tlast = last_of_run
//
// one item at a time: each byte passes the drain state before the next is taken;
// the second byte of a pair copies length + 3 bytes, one copied byte per
// cycle while not stalled, through the single read port of the history ring
// a stalled result holds the emit stage, and with it the item
// end_of_stream returns the decoder and ring pointers to reset after the item;
// the ring is not swept, a fill count makes unwritten entries read as zero
module lzss_ring_decompressor_top #(
  parameter int RING_BITS        = lzssrd_pkg::DEF_RING_BITS,
  parameter int START_GAP        = lzssrd_pkg::DEF_START_GAP,
  parameter int BYTES_PER_RESULT = lzssrd_pkg::DEF_BYTES_PER_RESULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lzssrd_pkg::IN_TDATA_W-1:0]   in_tdata,  // in_byte
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lzssrd_pkg::OUT_TDATA_W-1:0]  out_tdata, // out_bytes, byte_count
  output logic                                out_tlast
);

  lzssrd_pkg::cmd_t  cmd;
  lzssrd_pkg::stat_t stat;
  logic [lzssrd_pkg::WORD_W-1:0]    out_word;
  logic [lzssrd_pkg::OUT_CNT_W-1:0] out_cnt;

  lzssrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_byte   (in_tdata[lzssrd_pkg::BYTE_W-1:0]),
    .in_last   (in_tlast),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  lzssrd_dp #(
    .RING_BITS        (RING_BITS),
    .START_GAP        (START_GAP),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_tdata[lzssrd_pkg::BYTE_W-1:0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_word   (out_word),
    .out_cnt    (out_cnt),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b00000, out_cnt, out_word};

endmodule

// ===== tb/tb_top.sv =====
// testbench for the lzss ring decompressor: directed table and random streams
`timescale 1ns / 100ps

module tb_top;

  localparam int RB       = lzssrd_pkg::DEF_RING_BITS;
  localparam int RING_LEN = 1 << RB;
  localparam int HI_BITS  = RB - 8;
  localparam int SETTLE   = 200;
  localparam int WW       = lzssrd_pkg::WORD_W;
  localparam int CW       = lzssrd_pkg::OUT_CNT_W;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_chk_t;

  typedef struct packed {
    logic [WW-1:0] word;
    logic [CW-1:0] cnt;
    logic          last;
  } res_t;

  typedef struct packed {
    logic [7:0]    b;
    logic          eos;
    row_chk_t      chk;
    logic [WW-1:0] word;
    logic [CW-1:0] cnt;
  } dir_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_tvalid = 1'b0;
  logic                               in_tready;
  logic [lzssrd_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                               in_tlast = 1'b0;
  logic                               out_tvalid;
  logic                               out_tready = 1'b0;
  logic [lzssrd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                               out_tlast;

  lzss_ring_decompressor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder mirror
  logic [7:0]         hist [RING_LEN];
  logic [RB-1:0]      wr_pos;
  logic [7:0]         flag_bits;
  logic [3:0]         flags_rem;
  lzssrd_pkg::phase_t phase;
  logic [7:0]         pos_low;
  logic [31:0]        acc_word;
  int                 acc_n;

  res_t decoded_words[$];
  res_t due_words[$];

  int  n_err;
  int  items_sent;
  bit  in_calm;
  int  stream_pos;
  int  stream_cut;
  bit  stream_over;

  function automatic void decoder_reset();
    foreach (hist[i]) hist[i] = 8'h00;
    wr_pos    = RB'(RING_LEN - lzssrd_pkg::DEF_START_GAP);
    flag_bits = 8'h00;
    flags_rem = 4'd0;
    phase     = lzssrd_pkg::PH_FLAG;
    pos_low   = 8'h00;
  endfunction

  function automatic void put_byte(input logic [7:0] v);
    hist[wr_pos] = v;
    wr_pos       = wr_pos + 1'b1;
    acc_word     = acc_word | (32'(v) << (8 * acc_n));
    acc_n++;
    if (acc_n == lzssrd_pkg::DEF_BYTES_PER_RESULT) begin
      decoded_words.push_back('{acc_word, CW'(acc_n), 1'b0});
      acc_word = '0;
      acc_n    = 0;
    end
  endfunction

  function automatic void take_flag();
    flag_bits = flag_bits >> 1;
    flags_rem = flags_rem - 1'b1;
    phase     = (flags_rem == 4'd0) ? lzssrd_pkg::PH_FLAG : lzssrd_pkg::PH_TOKEN;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic eos);
    logic [RB-1:0] pos;
    logic [RB-1:0] rd;
    int            len;
    decoded_words.delete();
    acc_word = '0;
    acc_n    = 0;
    case (phase)
      lzssrd_pkg::PH_TOKEN: begin
        if (flag_bits[0]) begin
          put_byte(b);
          take_flag();
        end else begin
          pos_low = b;
          phase   = lzssrd_pkg::PH_PAIR;
        end
      end
      lzssrd_pkg::PH_PAIR: begin
        pos = {b[7 -: HI_BITS], pos_low};
        len = int'(b & (8'hFF >> HI_BITS)) + lzssrd_pkg::LEN_OFFSET;
        for (int k = 0; k < len; k++) begin
          rd = pos + RB'(k);
          put_byte(hist[rd]);
        end
        take_flag();
      end
      default: begin
        flag_bits = b;
        flags_rem = 4'(lzssrd_pkg::FLAG_COUNT);
        phase     = lzssrd_pkg::PH_TOKEN;
      end
    endcase
    if (acc_n > 0)
      decoded_words.push_back('{acc_word, CW'(acc_n), 1'b1});
    else if (decoded_words.size() > 0)
      decoded_words[decoded_words.size() - 1].last = 1'b1;
    if (eos)
      decoder_reset();
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    else if (r < 92)
      return $urandom_range(1, 3);
    else
      return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eos, input row_chk_t chk,
                           input logic [WW-1:0] word, input logic [CW-1:0] cnt);
    int gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // beat accepted at this edge
    decode_byte(b, eos);
    case (chk)
      CHK_MODEL: foreach (decoded_words[i]) due_words.push_back(decoded_words[i]);
      CHK_ONE:   due_words.push_back('{word, cnt, 1'b1});
      default:   ;
    endcase
    items_sent++;
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic push_tok(input logic [7:0] b, input bit is_final);
    logic eos;
    if (!stream_over) begin
      eos = is_final || (stream_pos == stream_cut);
      send_item(b, eos, CHK_MODEL, '0, '0);
      stream_pos++;
      if (eos)
        stream_over = 1'b1;
    end
  endtask

  task automatic run_stream();
    int            groups;
    int            r;
    logic [7:0]    fl;
    logic [RB-1:0] pos;
    logic [6:0]    lc;
    bit            fin;
    groups      = $urandom_range(1, 6);
    in_calm     = ($urandom_range(0, 3) == 0);
    stream_pos  = 0;
    stream_over = 1'b0;
    stream_cut  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, groups * 12) : -1;
    for (int g = 0; g < groups; g++) begin
      r  = $urandom_range(0, 9);
      fl = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
      push_tok(fl, 1'b0);
      for (int t = 0; t < lzssrd_pkg::FLAG_COUNT; t++) begin
        fin = (g == groups - 1) && (t == lzssrd_pkg::FLAG_COUNT - 1);
        if (fl[t]) begin
          push_tok(8'($urandom), fin);
        end else begin
          // near copies reach recent output and overlap it
          if ($urandom_range(0, 9) < 6)
            pos = wr_pos - RB'($urandom_range(1, 32));
          else
            pos = RB'($urandom);
          r = $urandom_range(0, 99);
          if (r < 80)
            lc = 7'($urandom_range(0, 12));
          else if (r < 95)
            lc = 7'($urandom_range(13, 60));
          else
            lc = 7'($urandom_range(100, 127));
          push_tok(pos[7:0], 1'b0);
          push_tok({pos[RB-1 -: HI_BITS], lc}, fin);
        end
      end
    end
  endtask

  // random bytes with no structure, closed by end of stream
  task automatic run_noise();
    int n;
    in_calm = 1'b0;
    n = $urandom_range(5, 20);
    for (int i = 0; i < n; i++) begin
      send_item(8'($urandom), i == n - 1, CHK_MODEL, '0, '0);
    end
  endtask

  dir_row_t dir_tab [25] = '{
    '{8'h00, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},  // flag: all pairs
    '{8'h00, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},
    '{8'h80, 1'b0, CHK_ONE,   32'h0000_0000, 3'd3},  // shortest copy of zeros
    '{8'hFF, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},
    '{8'h7F, 1'b0, CHK_MODEL, 32'h0000_0000, 3'd0},  // longest copy
    '{8'h12, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},
    '{8'h01, 1'b0, CHK_MODEL, 32'h0000_0000, 3'd0},
    '{8'h34, 1'b1, CHK_NONE,  32'h0000_0000, 3'd0},  // ends on lone position byte
    '{8'hFF, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},  // flag: all literals
    '{8'hFF, 1'b0, CHK_ONE,   32'h0000_00FF, 3'd1},
    '{8'h00, 1'b0, CHK_ONE,   32'h0000_0000, 3'd1},
    '{8'hA5, 1'b0, CHK_ONE,   32'h0000_00A5, 3'd1},
    '{8'h5A, 1'b0, CHK_ONE,   32'h0000_005A, 3'd1},
    '{8'h80, 1'b0, CHK_ONE,   32'h0000_0080, 3'd1},
    '{8'h01, 1'b0, CHK_ONE,   32'h0000_0001, 3'd1},
    '{8'h7E, 1'b0, CHK_ONE,   32'h0000_007E, 3'd1},
    '{8'hC3, 1'b0, CHK_ONE,   32'h0000_00C3, 3'd1},
    '{8'hAA, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},  // pair and literal in turn
    '{8'hBE, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},
    '{8'h81, 1'b0, CHK_MODEL, 32'h0000_0000, 3'd0},  // reads back the literals
    '{8'h3C, 1'b0, CHK_ONE,   32'h0000_003C, 3'd1},
    '{8'hCA, 1'b0, CHK_NONE,  32'h0000_0000, 3'd0},
    '{8'h87, 1'b0, CHK_MODEL, 32'h0000_0000, 3'd0},  // overlapping copy
    '{8'h99, 1'b1, CHK_ONE,   32'h0000_0099, 3'd1},
    '{8'h5C, 1'b1, CHK_NONE,  32'h0000_0000, 3'd0}   // ends right after a flag
  };

  initial begin
    n_err      = 0;
    items_sent = 0;
    in_calm    = 1'b0;
    decoder_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i])
      send_item(dir_tab[i].b, dir_tab[i].eos, dir_tab[i].chk, dir_tab[i].word, dir_tab[i].cnt);
    drain_all();
    while (items_sent < 390) begin
      if ($urandom_range(0, 9) == 0)
        run_noise();
      else
        run_stream();
      // close a stream cut short by neither an end nor a cut
      if (!stream_over && phase != lzssrd_pkg::PH_FLAG)
        send_item(8'($urandom), 1'b1, CHK_MODEL, '0, '0);
      if ($urandom_range(0, 3) == 0)
        drain_all();
    end
    in_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (n_err == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // result side back-pressure
  initial begin
    int gap;
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
      hold = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[WW-1:0], out_tdata[WW +: CW], out_tlast};
      if (due_words.size() == 0) begin
        $display("%0t: unexpected beat bytes=%h count=%0d last=%b",
                 $time, got.word, got.cnt, got.last);
        n_err++;
      end else begin
        want = due_words.pop_front();
        if (got.word !== want.word) begin
          $display("%0t: out_bytes expected %h actual %h", $time, want.word, got.word);
          n_err++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%0t: byte_count expected %0d actual %0d", $time, want.cnt, got.cnt);
          n_err++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last, got.last);
          n_err++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
